// ===== src/dsq_pkg.sv =====
// ----------------------------------------------------------------------------
// dsq_pkg
// Field widths, result codes and the queue entry type of the delta sleep queue.
// ----------------------------------------------------------------------------
package dsq_pkg;

    localparam int ID_W        = 8;
    localparam int PRIO_W      = 8;
    localparam int MS_W        = 32;
    localparam int DELTA_W     = 27;
    localparam int STATUS_W    = 3;
    localparam int MAX_RESULTS = 16;

    localparam logic [DELTA_W-1:0] DELTA_MAX = '1;

    localparam logic REQ_SLEEP = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_SLEPT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WOKEN     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TICK_NONE = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [DELTA_W-1:0] delta;
    } entry_t;

endpackage

// ===== src/delta_sleep_queue.sv =====
// ----------------------------------------------------------------------------
// delta_sleep_queue
// Sleep queue kept as a sorted delta list in a circular entry memory.
// ----------------------------------------------------------------------------
// Sleep item: zero ticks or a full queue go straight to the result;
//   otherwise the reciprocal divide, the walk over the entries, the shift
//   of any later entries, the insert and the result follow in that order.
// Tick item: the head delta drops, or heads at zero go, up to MAX_RESULTS.
// One item at a time; the entry memory port sets the walk and shift pace.
// Reset empties the queue at once; entry contents stay undefined.
module delta_sleep_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICK_MS     = 50
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [dsq_pkg::ID_W-1:0]     proc_id,
    input  logic [dsq_pkg::PRIO_W-1:0]   proc_priority,
    input  logic [dsq_pkg::MS_W-1:0]     sleep_ms,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dsq_pkg::STATUS_W-1:0] status,
    output logic [dsq_pkg::ID_W-1:0]     woken_id,
    output logic [dsq_pkg::PRIO_W-1:0]   woken_priority,
    output logic                         last
);
    import dsq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_WALK,
        S_SHIFT,
        S_INS,
        S_RES,
        S_TK_DEC,
        S_TK_CHK,
        S_TK_LAST
    } state_t;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] ofs);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(ofs);
        if (s >= (CW+1)'(QUEUE_DEPTH))
            s = s - (CW+1)'(QUEUE_DEPTH);
        return s[AW-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [DELTA_W-1:0]    t_reg, t_next;
    logic [DELTA_W-1:0]    dmod_reg, dmod_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [PRIO_W-1:0]     pr_reg, pr_next;
    logic [ID_W-1:0]       cur_id_reg, cur_id_next;
    logic [PRIO_W-1:0]     cur_pr_reg, cur_pr_next;
    logic [RW-1:0]         nrel_reg, nrel_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ID_W-1:0]       woken_id_reg;
    logic [PRIO_W-1:0]     woken_priority_reg;
    logic                  last_reg;

    entry_t                mem [QUEUE_DEPTH];
    entry_t                rd_data_reg;
    entry_t                wr_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    logic                  div_start;
    logic                  div_done;
    logic [MS_W-1:0]       div_q;

    logic                  in_accept;
    logic                  out_free;
    logic                  emit;
    logic [STATUS_W-1:0]   emit_status;
    logic [ID_W-1:0]       emit_id;
    logic [PRIO_W-1:0]     emit_pr;
    logic                  emit_last;
    logic [DELTA_W-1:0]    dec_delta;
    logic [RW-1:0]         nrel_inc;

    dsq_div #(
        .DIVISOR (TICK_MS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sleep_ms),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_stall  = state_reg != S_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        t_next          = t_reg;
        dmod_next       = dmod_reg;
        id_next         = id_reg;
        pr_next         = pr_reg;
        cur_id_next     = cur_id_reg;
        cur_pr_next     = cur_pr_reg;
        nrel_next       = nrel_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        div_start       = 1'b0;
        emit            = 1'b0;
        emit_status     = ST_WOKEN;
        emit_id         = cur_id_reg;
        emit_pr         = cur_pr_reg;
        emit_last       = 1'b1;
        dec_delta       = (rd_data_reg.delta != '0) ? rd_data_reg.delta - DELTA_W'(1) : '0;
        nrel_inc        = nrel_reg + RW'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    id_next = proc_id;
                    pr_next = proc_priority;
                    if (req_type == REQ_TICK)
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_status_next = ST_TICK_NONE;
                            state_next      = S_RES;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_TK_DEC;
                        end
                    end
                    else if (sleep_ms < MS_W'(TICK_MS))
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_RES;
                    end
                    else if (cnt_reg == CW'(QUEUE_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RES;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    t_next   = (div_q[MS_W-1:DELTA_W] != '0) ? DELTA_MAX : div_q[DELTA_W-1:0];
                    pos_next = '0;
                    if (cnt_reg == '0)
                        state_next = S_INS;
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head_reg;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (rd_data_reg.delta > t_reg ||
                    (rd_data_reg.delta == t_reg && rd_data_reg.prio > pr_reg))
                begin
                    dmod_next  = rd_data_reg.delta - t_reg;
                    idx_next   = cnt_reg - CW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, cnt_reg - CW'(1));
                    state_next = S_SHIFT;
                end
                else
                begin
                    t_next   = t_reg - rd_data_reg.delta;
                    pos_next = pos_reg + CW'(1);
                    if (pos_reg + CW'(1) == cnt_reg)
                        state_next = S_INS;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = phys(head_reg, pos_reg + CW'(1));
                    end
                end
            end
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, idx_reg + CW'(1));
                if (idx_reg == pos_reg)
                begin
                    wr_data.delta = dmod_reg;
                    state_next    = S_INS;
                end
                else
                begin
                    idx_next = idx_reg - CW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = phys(head_reg, idx_reg - CW'(1));
                end
            end
            S_INS:
            begin
                wr_en           = 1'b1;
                wr_addr         = phys(head_reg, pos_reg);
                wr_data.id      = id_reg;
                wr_data.prio    = pr_reg;
                wr_data.delta   = t_reg;
                cnt_next        = cnt_reg + CW'(1);
                res_status_next = ST_SLEPT;
                state_next      = S_RES;
            end
            S_RES:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = res_status_reg;
                    emit_id     = '0;
                    emit_pr     = '0;
                    state_next  = S_IDLE;
                end
            end
            S_TK_DEC:
            begin
                if (dec_delta != '0)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = head_reg;
                    wr_data.delta   = dec_delta;
                    res_status_next = ST_TICK_NONE;
                    state_next      = S_RES;
                end
                else
                begin
                    cur_id_next = rd_data_reg.id;
                    cur_pr_next = rd_data_reg.prio;
                    head_next   = phys(head_reg, CW'(1));
                    cnt_next    = cnt_reg - CW'(1);
                    nrel_next   = RW'(1);
                    if (cnt_reg == CW'(1) || RW'(1) == RW'(MAX_RESULTS))
                        state_next = S_TK_LAST;
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = phys(head_reg, CW'(1));
                        state_next = S_TK_CHK;
                    end
                end
            end
            S_TK_CHK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (rd_data_reg.delta == '0)
                    begin
                        emit_last   = 1'b0;
                        cur_id_next = rd_data_reg.id;
                        cur_pr_next = rd_data_reg.prio;
                        head_next   = phys(head_reg, CW'(1));
                        cnt_next    = cnt_reg - CW'(1);
                        nrel_next   = nrel_inc;
                        if (cnt_reg == CW'(1) || nrel_inc == RW'(MAX_RESULTS))
                            state_next = S_TK_LAST;
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = phys(head_reg, CW'(1));
                        end
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_TK_LAST:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            head_reg           <= '0;
            cnt_reg            <= '0;
            pos_reg            <= '0;
            idx_reg            <= '0;
            t_reg              <= '0;
            dmod_reg           <= '0;
            id_reg             <= '0;
            pr_reg             <= '0;
            cur_id_reg         <= '0;
            cur_pr_reg         <= '0;
            nrel_reg           <= '0;
            res_status_reg     <= ST_SLEPT;
            out_valid_reg      <= 1'b0;
            status_reg         <= ST_SLEPT;
            woken_id_reg       <= '0;
            woken_priority_reg <= '0;
            last_reg           <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            idx_reg        <= idx_next;
            t_reg          <= t_next;
            dmod_reg       <= dmod_next;
            id_reg         <= id_next;
            pr_reg         <= pr_next;
            cur_id_reg     <= cur_id_next;
            cur_pr_reg     <= cur_pr_next;
            nrel_reg       <= nrel_next;
            res_status_reg <= res_status_next;
            if (emit)
            begin
                out_valid_reg      <= 1'b1;
                status_reg         <= emit_status;
                woken_id_reg       <= emit_id;
                woken_priority_reg <= emit_pr;
                last_reg           <= emit_last;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign woken_id       = woken_id_reg;
    assign woken_priority = woken_priority_reg;
    assign last           = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_release_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nrel_reg <= RW'(MAX_RESULTS))
        else $error("too many releases on one tick");

    a_chk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TK_CHK |-> cnt_reg != '0)
        else $error("release check on an empty queue");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(status_reg) && $stable(woken_id_reg))
        else $error("held result overwritten");

endmodule

// ===== src/dsq_div.sv =====
// ----------------------------------------------------------------------------
// dsq_div
// Divider by a fixed divisor: reciprocal multiply, then remainder correction.
// ----------------------------------------------------------------------------
module dsq_div #(
    parameter int DIVISOR = 50
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [dsq_pkg::MS_W-1:0] dividend,
    output logic                     done,
    output logic [dsq_pkg::MS_W-1:0] quotient
);
    import dsq_pkg::*;

    localparam logic [MS_W-1:0] DIV_C = MS_W'(DIVISOR);
    localparam logic [MS_W-1:0] RECIP = {MS_W{1'b1}} / DIV_C;

    typedef enum logic [1:0] {
        P_IDLE,
        P_MUL,
        P_REM,
        P_FIX
    } phase_t;

    phase_t            phase_reg;
    logic [MS_W-1:0]   x_reg;
    logic [MS_W-1:0]   q_reg;
    logic [MS_W-1:0]   r_reg;
    logic              done_reg;
    logic [2*MS_W-1:0] prod;
    logic [MS_W-1:0]   qd;

    always_comb
    begin
        prod = (2*MS_W)'(x_reg) * (2*MS_W)'(RECIP);
        qd   = q_reg * DIV_C;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            x_reg     <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == P_FIX) && (r_reg < DIV_C);
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= dividend;
                        phase_reg <= P_MUL;
                    end
                end
                P_MUL:
                begin
                    q_reg     <= prod[2*MS_W-1:MS_W];
                    phase_reg <= P_REM;
                end
                P_REM:
                begin
                    r_reg     <= x_reg - qd;
                    phase_reg <= P_FIX;
                end
                P_FIX:
                begin
                    if (r_reg >= DIV_C)
                    begin
                        q_reg <= q_reg + MS_W'(1);
                        r_reg <= r_reg - DIV_C;
                    end
                    else
                    begin
                        phase_reg <= P_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
